/* rtl/kway_merge_4ary_heap_defines.svh */
// Assertion macros shared by the RTL of the k-way merge heap.
// Depends on nothing; included by the files that carry assertions.
`ifndef KWAY_MERGE_4ARY_HEAP_DEFINES_SVH
`define KWAY_MERGE_4ARY_HEAP_DEFINES_SVH

`ifndef SYNTHESIS
`define KWM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kwm assertion failed");
`define KWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kwm assertion failed");
`else
`define KWM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define KWM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/kwm_pkg.sv */
// Types and codes of the k-way merge heap.
// Depends on nothing; imported by the top level.
package kwm_pkg;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_REFILL = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLD_RD,
    S_NODE_WAIT,
    S_RF_SRC,
    S_LVL,
    S_SCAN,
    S_DECIDE,
    S_NEXT,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_t;

endpackage

/* rtl/kwm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module kwm_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/kway_merge_4ary_heap.sv */
// K-way merge of descending lists on a 4-ary max-heap held in one RAM.
// A load without the last mark writes its entry into the RAM while idle. A refill walks
// the new value down the heap, at most 3 levels for 64 lists; each level reads up to
// four children through the single RAM read port and compares them in turn. A last
// load builds the heap, sifting down each parent node. Reset clears the control state,
// the list count and the strobe only; the receiver cannot stall.
`include "kway_merge_4ary_heap_defines.svh"

module kway_merge_4ary_heap #(
  parameter int MAX_LISTS  = 64,
  parameter int VALUE_BITS = 31
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func,
  input  logic [$clog2(MAX_LISTS)-1:0] list_id,
  input  logic [VALUE_BITS-1:0]        value,
  input  logic                         last_list,
  output logic                         strobe,
  output logic [VALUE_BITS-1:0]        top_value,
  output logic [$clog2(MAX_LISTS)-1:0] top_list,
  output logic                         done_res
);
  import kwm_pkg::*;

  localparam int IDW = $clog2(MAX_LISTS);
  localparam int CW  = $clog2(MAX_LISTS + 1);
  localparam int XW  = $clog2(4 * MAX_LISTS + 1);
  localparam int DW  = VALUE_BITS + IDW;

  state_t state, state_next;

  logic [CW-1:0]         count;
  logic                  refill;
  logic [IDW-1:0]        node;
  logic [IDW-1:0]        pos;
  logic [VALUE_BITS-1:0] kv;
  logic [IDW-1:0]        ks;
  logic [XW-1:0]         scan_idx;
  logic [1:0]            k;
  logic [VALUE_BITS-1:0] best_key;
  logic [IDW-1:0]        best_src;
  logic [IDW-1:0]        best_i;

  logic                  we;
  logic [IDW-1:0]        waddr;
  logic [DW-1:0]         wdata;
  logic [IDW-1:0]        raddr;
  logic [DW-1:0]         rdata;

  logic                  accept;
  logic                  id_ok;
  logic [XW-1:0]         child;
  logic [XW-1:0]         count_x;
  logic [XW-1:0]         scan_next;
  logic                  scan_last;
  logic [VALUE_BITS-1:0] rkey;
  logic [IDW-1:0]        rsrc;
  logic                  take;
  logic                  bld_stop;
  logic                  rf_swap;

  kwm_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_LISTS)
  ) u_heap (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy      = (state != S_IDLE);
  assign accept    = start && (state == S_IDLE);
  assign id_ok     = CW'(list_id) < CW'(MAX_LISTS);
  assign child     = XW'({pos, 2'b00}) + XW'(1);
  assign count_x   = XW'(count);
  assign scan_next = scan_idx + XW'(1);
  assign scan_last = (k == 2'd3) || (scan_next >= count_x);
  assign rkey      = rdata[DW-1:IDW];
  assign rsrc      = rdata[IDW-1:0];
  assign take      = (k == 2'd0) || (rkey > best_key);
  assign bld_stop  = !refill && (kv >= best_key);
  assign rf_swap   = refill && (kv > best_key);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (func == FUNC_REFILL) begin
            state_next = S_RF_SRC;
          end else if (id_ok && last_list) begin
            state_next = (list_id == '0) ? S_EMIT_RD : S_BLD_RD;
          end
        end
      end
      S_BLD_RD:    state_next = S_NODE_WAIT;
      S_NODE_WAIT: state_next = S_LVL;
      S_RF_SRC:    state_next = S_LVL;
      S_LVL:       state_next = (child >= count_x) ? S_NEXT : S_SCAN;
      S_SCAN:      state_next = scan_last ? S_DECIDE : S_SCAN;
      S_DECIDE:    state_next = bld_stop ? S_NEXT : S_LVL;
      S_NEXT:      state_next = (refill || node == '0) ? S_EMIT_RD : S_BLD_RD;
      S_EMIT_RD:   state_next = S_EMIT_WAIT;
      S_EMIT_WAIT: state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = {kv, ks};
    raddr = pos;
    unique case (state)
      S_IDLE: begin
        we    = accept && (func == FUNC_LOAD) && id_ok;
        waddr = list_id;
        wdata = {value, list_id};
        raddr = '0;
      end
      S_BLD_RD: raddr = node;
      S_LVL: begin
        if (child >= count_x) begin
          we = 1'b1;
        end else begin
          raddr = child[IDW-1:0];
        end
      end
      S_SCAN: begin
        if (!scan_last) begin
          raddr = scan_next[IDW-1:0];
        end
      end
      S_DECIDE: begin
        we = 1'b1;
        if (!bld_stop && !rf_swap) begin
          wdata = {best_key, best_src};
        end
      end
      S_EMIT_RD: raddr = '0;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (func == FUNC_REFILL) begin
              kv     <= value;
              pos    <= '0;
              refill <= 1'b1;
            end else if (id_ok && last_list) begin
              count  <= CW'(list_id) + CW'(1);
              refill <= 1'b0;
              node   <= IDW'((list_id - IDW'(1)) >> 2);
            end
          end
        end
        S_BLD_RD: pos <= node;
        S_NODE_WAIT: begin
          kv <= rkey;
          ks <= rsrc;
        end
        S_RF_SRC: ks <= rsrc;
        S_LVL: begin
          scan_idx <= child;
          k        <= 2'd0;
        end
        S_SCAN: begin
          if (take) begin
            best_key <= rkey;
            best_src <= rsrc;
            best_i   <= scan_idx[IDW-1:0];
          end
          k        <= k + 2'd1;
          scan_idx <= scan_next;
        end
        S_DECIDE: begin
          if (rf_swap) begin
            kv <= best_key;
            ks <= best_src;
          end
          if (!bld_stop) begin
            pos <= best_i;
          end
        end
        S_NEXT: begin
          if (!(refill || node == '0)) begin
            node <= node - IDW'(1);
          end
        end
        S_EMIT_WAIT: begin
          top_value <= rkey;
          top_list  <= rsrc;
          done_res  <= (rkey == '0);
          strobe    <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  `KWM_ASSERT_IMPLIES(a_strobe_src, clk, rst, strobe, $past(state) == S_EMIT_WAIT)
  `KWM_ASSERT_IMPLIES(a_done_flag, clk, rst, strobe, done_res == (top_value == '0))
  `KWM_ASSERT_NEXT(a_refill_busy, clk, rst, accept && func == FUNC_REFILL, busy)
  `KWM_ASSERT_IMPLIES(a_scan_range, clk, rst, state == S_SCAN, scan_idx < count_x)
  `KWM_ASSERT_IMPLIES(a_child_below, clk, rst, state == S_DECIDE, best_i > pos)

endmodule
